// ===== hdl/dsn_pkg.sv =====
// shared types, constants and the microcode program of the noise field generator
package dsn_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_SUPPLY  = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // fixed-point constants, q1.31
  localparam logic [31:0] BIAS_0P8 = 32'd1717986918;
  localparam logic [31:0] MUL_0P3  = 32'd644245094;
  localparam logic [31:0] MOD_ONE  = 32'h8000_0000;

  localparam logic [2:0] FEAT_RST = 3'd4;

  typedef enum logic [2:0] {
    PH_SEED,
    PH_DIAMOND,
    PH_EDGE_H,
    PH_EDGE_G,
    PH_DONE
  } phase_t;

  // sample addresses relative to the cursor (x, y), step s, half step h
  typedef enum logic [3:0] {
    AS_CUR,    // (x, y)
    AS_XS,     // (x+s, y)
    AS_YS,     // (x, y+s)
    AS_XSYS,   // (x+s, y+s)
    AS_XHYH,   // (x+h, y+h)
    AS_XHYMH,  // (x+h, y-h)
    AS_XMHYH,  // (x-h, y+h)
    AS_XH,     // (x+h, y)
    AS_YH,     // (x, y+h)
    AS_REQ     // requested read location
  } addr_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_JIT,    // |jitter| * pass scale
    MUL_SCALE,  // pass scale * (modifier + 0.8)
    MUL_MOD     // modifier * 0.3
  } mul_op_t;

  typedef enum logic [2:0] {
    CO_NONE,
    CO_RESTART,
    CO_SEED_ADV,
    CO_DIA_ADV,
    CO_TO_G,
    CO_EG_ADV,
    CO_END
  } cur_op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_DISPATCH,
    JC_WRAP,       // wrap ? target : idle
    JC_HOLD_BUSY   // out busy ? stay : target
  } jmp_t;

  localparam int UPC_W = 5;

  // microcode addresses
  localparam logic [UPC_W-1:0] UA_IDLE = 5'd0;
  localparam logic [UPC_W-1:0] UA_RD0  = 5'd1;
  localparam logic [UPC_W-1:0] UA_RD1  = 5'd2;
  localparam logic [UPC_W-1:0] UA_RST  = 5'd3;
  localparam logic [UPC_W-1:0] UA_SEED = 5'd4;
  localparam logic [UPC_W-1:0] UA_DI0  = 5'd5;
  localparam logic [UPC_W-1:0] UA_DI1  = 5'd6;
  localparam logic [UPC_W-1:0] UA_DI2  = 5'd7;
  localparam logic [UPC_W-1:0] UA_DI3  = 5'd8;
  localparam logic [UPC_W-1:0] UA_DI4  = 5'd9;
  localparam logic [UPC_W-1:0] UA_DI5  = 5'd10;
  localparam logic [UPC_W-1:0] UA_EH0  = 5'd11;
  localparam logic [UPC_W-1:0] UA_EH1  = 5'd12;
  localparam logic [UPC_W-1:0] UA_EH2  = 5'd13;
  localparam logic [UPC_W-1:0] UA_EH3  = 5'd14;
  localparam logic [UPC_W-1:0] UA_EH4  = 5'd15;
  localparam logic [UPC_W-1:0] UA_EH5  = 5'd16;
  localparam logic [UPC_W-1:0] UA_EG0  = 5'd17;
  localparam logic [UPC_W-1:0] UA_EG1  = 5'd18;
  localparam logic [UPC_W-1:0] UA_EG2  = 5'd19;
  localparam logic [UPC_W-1:0] UA_EG3  = 5'd20;
  localparam logic [UPC_W-1:0] UA_EG4  = 5'd21;
  localparam logic [UPC_W-1:0] UA_EG5  = 5'd22;
  localparam logic [UPC_W-1:0] UA_END0 = 5'd23;
  localparam logic [UPC_W-1:0] UA_END1 = 5'd24;
  localparam logic [UPC_W-1:0] UA_END2 = 5'd25;

  typedef struct packed {
    logic             rd_en;
    addr_sel_t        rd_sel;
    logic             wr_en;
    addr_sel_t        wr_sel;
    logic             wr_seed;   // write seed value instead of blend
    acc_op_t          acc_op;
    mul_op_t          mul_op;
    logic             term_ld;
    logic             half;      // edge passes halve the jitter term
    logic             scale_ld;
    logic             mod_ld;
    cur_op_t          cur_op;
    logic             out_ld;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    phase_t phase;
    logic   wrap;
    logic   out_busy;
  } dsn_status_t;

  // one blend routine: four neighbor reads, jitter multiply, one write
  function automatic ctrl_word_t blend_step(input logic [2:0] n, input addr_sel_t nb2,
                                            input addr_sel_t nb3, input addr_sel_t nb4,
                                            input addr_sel_t dst, input logic half);
    ctrl_word_t w;
    w = '0;
    w.half = half;
    case (n)
      3'd0: begin
        w.rd_en  = 1'b1;
        w.rd_sel = AS_CUR;
        w.mul_op = MUL_JIT;
      end
      3'd1: begin
        w.rd_en  = 1'b1;
        w.rd_sel = nb2;
        w.acc_op = ACC_LOAD;
      end
      3'd2: begin
        w.rd_en   = 1'b1;
        w.rd_sel  = nb3;
        w.acc_op  = ACC_ADD;
        w.term_ld = 1'b1;
      end
      3'd3: begin
        w.rd_en  = 1'b1;
        w.rd_sel = nb4;
        w.acc_op = ACC_ADD;
      end
      3'd4: begin
        w.acc_op = ACC_ADD;
      end
      default: begin
        w.wr_en  = 1'b1;
        w.wr_sel = dst;
        w.jmp    = JC_GOTO;
        w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

  // the control store
  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_word_t w;
    w = '0;
    case (addr)
      UA_IDLE: begin
        w.jmp = JC_DISPATCH;
      end
      UA_RD0: begin
        w.rd_en  = 1'b1;
        w.rd_sel = AS_REQ;
      end
      UA_RD1: begin
        w.out_ld = 1'b1;
        w.jmp    = JC_HOLD_BUSY;
        w.target = UA_IDLE;
      end
      UA_RST: begin
        w.cur_op = CO_RESTART;
        w.jmp    = JC_GOTO;
        w.target = UA_IDLE;
      end
      UA_SEED: begin
        w.wr_en   = 1'b1;
        w.wr_sel  = AS_CUR;
        w.wr_seed = 1'b1;
        w.cur_op  = CO_SEED_ADV;
        w.jmp     = JC_GOTO;
        w.target  = UA_IDLE;
      end
      UA_DI0, UA_DI1, UA_DI2, UA_DI3, UA_DI4, UA_DI5: begin
        w = blend_step(3'(addr - UA_DI0), AS_XS, AS_YS, AS_XSYS, AS_XHYH, 1'b0);
        if (addr == UA_DI5) begin
          w.cur_op = CO_DIA_ADV;
        end
      end
      UA_EH0, UA_EH1, UA_EH2, UA_EH3, UA_EH4, UA_EH5: begin
        w = blend_step(3'(addr - UA_EH0), AS_XS, AS_XHYH, AS_XHYMH, AS_XH, 1'b1);
        if (addr == UA_EH5) begin
          w.cur_op = CO_TO_G;
        end
      end
      UA_EG0, UA_EG1, UA_EG2, UA_EG3, UA_EG4, UA_EG5: begin
        w = blend_step(3'(addr - UA_EG0), AS_YS, AS_XHYH, AS_XMHYH, AS_YH, 1'b1);
        if (addr == UA_EG5) begin
          w.cur_op = CO_EG_ADV;
          w.jmp    = JC_WRAP;
          w.target = UA_END0;
        end
      end
      UA_END0: begin
        w.mul_op = MUL_SCALE;
      end
      UA_END1: begin
        w.scale_ld = 1'b1;
        w.mul_op   = MUL_MOD;
      end
      UA_END2: begin
        w.mod_ld = 1'b1;
        w.cur_op = CO_END;
        w.jmp    = JC_GOTO;
        w.target = UA_IDLE;
      end
      default: begin
        w.jmp    = JC_GOTO;
        w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/dsn_ram.sv =====
// generic single-write, single-read ram with registered read data
module dsn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dsn_seq.sv =====
// microcode sequencer: step counter, control store lookup and jump logic
module dsn_seq
  import dsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_req_type,
  input  dsn_status_t status,
  output logic        in_ready,
  output ctrl_word_t  ctrl
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic [UPC_W-1:0] dispatch;

  assign ctrl     = ucode(upc_r);
  assign in_ready = (upc_r == UA_IDLE);

  // entry point of the routine for an accepted request
  always_comb begin
    dispatch = UA_IDLE;
    if (in_valid) begin
      case (in_req_type)
        REQ_SUPPLY: begin
          case (status.phase)
            PH_SEED:    dispatch = UA_SEED;
            PH_DIAMOND: dispatch = UA_DI0;
            PH_EDGE_H:  dispatch = UA_EH0;
            PH_EDGE_G:  dispatch = UA_EG0;
            default:    dispatch = UA_IDLE;
          endcase
        end
        REQ_READ:    dispatch = UA_RD0;
        REQ_RESTART: dispatch = UA_RST;
        default:     dispatch = UA_IDLE;
      endcase
    end
  end

  always_comb begin
    case (ctrl.jmp)
      JC_NEXT:      upc_nxt = upc_r + 1'b1;
      JC_GOTO:      upc_nxt = ctrl.target;
      JC_DISPATCH:  upc_nxt = dispatch;
      JC_WRAP:      upc_nxt = status.wrap ? ctrl.target : UA_IDLE;
      JC_HOLD_BUSY: upc_nxt = status.out_busy ? upc_r : ctrl.target;
      default:      upc_nxt = UA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  a_read_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_READ |=> upc_r == UA_RD0)
    else $error("read request did not enter the read routine");

  a_end_of_pass: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == UA_EG5 && status.wrap |=> upc_r == UA_END0)
    else $error("finished edge sweep did not run the scale update");

endmodule

// ===== hdl/dsn_dp.sv =====
// datapath: cursor, step and scale state, neighbor addressing, blend arithmetic
module dsn_dp
  import dsn_pkg::*;
#(
  parameter int FIELD_LOG2 = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_word_t              ctrl,
  input  logic                    in_accept,
  input  logic [23:0]             in_random_fraction,
  input  logic [6:0]              in_read_x,
  input  logic [6:0]              in_read_y,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_feature_log2,
  output dsn_status_t             status,
  output logic                    ram_re,
  output logic [2*FIELD_LOG2-1:0] ram_raddr,
  output logic                    ram_we,
  output logic [2*FIELD_LOG2-1:0] ram_waddr,
  output logic [23:0]             ram_wdata,
  input  logic [23:0]             ram_rdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             out_sample_value,
  output logic                    out_field_done
);

  localparam int CW = FIELD_LOG2;
  localparam int AW = 2 * FIELD_LOG2;
  localparam logic [31:0] SCALE_RST = 32'(1) << (30 - FIELD_LOG2);

  function automatic logic [2:0] clamp_k(input logic [2:0] f);
    logic [2:0] k;
    k = f;
    if (f == 3'd0) begin
      k = 3'd1;
    end else if ({1'b0, f} > 4'(FIELD_LOG2)) begin
      k = 3'(FIELD_LOG2);
    end
    return k;
  endfunction

  function automatic logic [AW-1:0] nb_addr(input addr_sel_t sel,
                                            input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] s, input logic [CW-1:0] h,
                                            input logic [CW-1:0] rx, input logic [CW-1:0] ry);
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    ax = x;
    ay = y;
    case (sel)
      AS_CUR: begin
        ax = x;
        ay = y;
      end
      AS_XS:    ax = x + s;
      AS_YS:    ay = y + s;
      AS_XSYS: begin
        ax = x + s;
        ay = y + s;
      end
      AS_XHYH: begin
        ax = x + h;
        ay = y + h;
      end
      AS_XHYMH: begin
        ax = x + h;
        ay = y - h;
      end
      AS_XMHYH: begin
        ax = x - h;
        ay = y + h;
      end
      AS_XH:    ax = x + h;
      AS_YH:    ay = y + h;
      AS_REQ: begin
        ax = rx;
        ay = ry;
      end
      default: begin
        ax = x;
        ay = y;
      end
    endcase
    return {ay, ax};
  endfunction

  // control state
  logic [2:0]    feat_r;
  logic [CW-1:0] cx_r, cx_nxt;
  logic [CW-1:0] cy_r, cy_nxt;
  logic [2:0]    k_r, k_nxt;
  phase_t        phase_r, phase_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   scale_r, scale_nxt;
  logic [31:0]   mod_r, mod_nxt;
  logic          out_valid_r;

  // payload
  logic [23:0]   jit_mag_r;
  logic          jit_neg_r;
  logic [CW-1:0] rx_r, ry_r;
  logic [63:0]   prod_r;
  logic [25:0]   acc_r;
  logic [31:0]   term_r;
  logic [23:0]   out_sample_r;
  logic          out_done_r;

  // step geometry
  logic [CW:0]   step_w;
  logic [CW-1:0] s_c, h_c;
  logic [CW:0]   x_sum, y_sum;
  logic          x_wrap, wrap;
  logic [CW-1:0] adv_x, adv_y;

  assign step_w = (CW + 1)'(1) << k_r;
  assign s_c    = step_w[CW-1:0];
  assign h_c    = step_w[CW:1];
  assign x_sum  = {1'b0, cx_r} + step_w;
  assign y_sum  = {1'b0, cy_r} + step_w;
  assign x_wrap = x_sum[CW];
  assign wrap   = x_wrap & y_sum[CW];
  assign adv_x  = x_wrap ? '0 : x_sum[CW-1:0];
  assign adv_y  = x_wrap ? (y_sum[CW] ? '0 : y_sum[CW-1:0]) : cy_r;

  // jitter 2r-1 as sign and magnitude
  logic [23:0] in_jit_mag;
  logic        in_jit_neg;
  assign in_jit_neg = ~in_random_fraction[23];
  assign in_jit_mag = in_random_fraction[23] ? {1'b0, in_random_fraction[22:0]}
                                             : 24'h80_0000 - in_random_fraction;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    case (ctrl.mul_op)
      MUL_JIT: begin
        mul_a = {8'd0, jit_mag_r};
        mul_b = scale_r;
      end
      MUL_SCALE: begin
        mul_a = scale_r;
        mul_b = mod_r + BIAS_0P8;
      end
      MUL_MOD: begin
        mul_a = mod_r;
        mul_b = MUL_0P3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // jitter term: round half away from zero at shift 33-k (+1 on edges)
  logic [5:0]  sh1;
  logic [30:0] rnd;
  logic [31:0] term_mag, term_nxt;
  assign sh1      = 6'd32 - {3'd0, k_r} + {5'd0, ctrl.half};
  assign rnd      = 31'(prod_r >> sh1);
  assign term_mag = ({1'b0, rnd} + 32'd1) >> 1;
  assign term_nxt = jit_neg_r ? (32'd0 - term_mag) : term_mag;

  // scale updates, q1.31 rounding
  logic [64:0] scale_rsum;
  logic [31:0] scale_upd, mod_upd;
  assign scale_rsum = {1'b0, prod_r} + 65'h4000_0000;
  assign scale_upd  = (|scale_rsum[64:63]) ? 32'hFFFF_FFFF : scale_rsum[62:31];
  assign mod_upd    = scale_rsum[62:31];

  // four-neighbor mean, rounded
  logic        acc_neg;
  logic [25:0] acc_mag, mean_sum;
  logic [24:0] mean;
  assign acc_neg  = acc_r[25];
  assign acc_mag  = acc_neg ? (26'd0 - acc_r) : acc_r;
  assign mean_sum = acc_mag + 26'd2;
  assign mean     = acc_neg ? (25'd0 - {1'b0, mean_sum[25:2]}) : {1'b0, mean_sum[25:2]};

  logic signed [32:0] blend_sum;
  logic [23:0]        blend_val;
  assign blend_sum = $signed({{8{mean[24]}}, mean}) + $signed({term_r[31], term_r});
  always_comb begin
    if (blend_sum > 33'sd8388607) begin
      blend_val = 24'h7F_FFFF;
    end else if (blend_sum < -33'sd8388608) begin
      blend_val = 24'h80_0000;
    end else begin
      blend_val = blend_sum[23:0];
    end
  end

  // seed: jitter rounded to q4.20
  logic [24:0] seed_sum;
  logic [23:0] seed_val;
  assign seed_sum = {1'b0, jit_mag_r} + 25'd4;
  assign seed_val = jit_neg_r ? (24'd0 - {2'd0, seed_sum[24:3]}) : {2'd0, seed_sum[24:3]};

  logic [25:0] rdata_ext;
  assign rdata_ext = {{2{ram_rdata[23]}}, ram_rdata};

  // memory port
  assign ram_re    = ctrl.rd_en;
  assign ram_raddr = nb_addr(ctrl.rd_sel, cx_r, cy_r, s_c, h_c, rx_r, ry_r);
  assign ram_we    = ctrl.wr_en;
  assign ram_waddr = nb_addr(ctrl.wr_sel, cx_r, cy_r, s_c, h_c, rx_r, ry_r);
  assign ram_wdata = ctrl.wr_seed ? seed_val : blend_val;

  logic out_busy;
  assign out_busy = out_valid_r & ~out_ready;

  assign status.phase    = phase_r;
  assign status.wrap     = wrap;
  assign status.out_busy = out_busy;

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_field_done   = out_done_r;

  always_comb begin
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    k_nxt     = k_r;
    phase_nxt = phase_r;
    done_nxt  = done_r;
    case (ctrl.cur_op)
      CO_RESTART: begin
        k_nxt     = clamp_k(feat_r);
        cx_nxt    = '0;
        cy_nxt    = '0;
        phase_nxt = PH_SEED;
        done_nxt  = 1'b0;
      end
      CO_SEED_ADV: begin
        cx_nxt = adv_x;
        cy_nxt = adv_y;
        if (wrap) begin
          phase_nxt = PH_DIAMOND;
        end
      end
      CO_DIA_ADV: begin
        cx_nxt = adv_x;
        cy_nxt = adv_y;
        if (wrap) begin
          phase_nxt = PH_EDGE_H;
        end
      end
      CO_TO_G: begin
        phase_nxt = PH_EDGE_G;
      end
      CO_EG_ADV: begin
        cx_nxt = adv_x;
        cy_nxt = adv_y;
        if (!wrap) begin
          phase_nxt = PH_EDGE_H;
        end
      end
      CO_END: begin
        k_nxt = k_r - 3'd1;
        if (k_r >= 3'd2) begin
          phase_nxt = PH_DIAMOND;
        end else begin
          phase_nxt = PH_DONE;
          done_nxt  = 1'b1;
        end
      end
      default: begin
        k_nxt = k_r;
      end
    endcase

    scale_nxt = scale_r;
    mod_nxt   = mod_r;
    if (ctrl.cur_op == CO_RESTART) begin
      scale_nxt = SCALE_RST;
      mod_nxt   = MOD_ONE;
    end else begin
      if (ctrl.scale_ld) begin
        scale_nxt = scale_upd;
      end
      if (ctrl.mod_ld) begin
        mod_nxt = mod_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_r      <= FEAT_RST;
      cx_r        <= '0;
      cy_r        <= '0;
      k_r         <= clamp_k(FEAT_RST);
      phase_r     <= PH_SEED;
      done_r      <= 1'b0;
      scale_r     <= SCALE_RST;
      mod_r       <= MOD_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        feat_r <= cfg_feature_log2;
      end
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      k_r     <= k_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      scale_r <= scale_nxt;
      mod_r   <= mod_nxt;
      if (ctrl.out_ld && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      jit_mag_r <= in_jit_mag;
      jit_neg_r <= in_jit_neg;
      rx_r      <= CW'(in_read_x);
      ry_r      <= CW'(in_read_y);
    end
    if (ctrl.mul_op != MUL_NONE) begin
      prod_r <= mul_p;
    end
    case (ctrl.acc_op)
      ACC_LOAD: acc_r <= rdata_ext;
      ACC_ADD:  acc_r <= acc_r + rdata_ext;
      default:  acc_r <= acc_r;
    endcase
    if (ctrl.term_ld) begin
      term_r <= term_nxt;
    end
    if (ctrl.out_ld && !out_busy) begin
      out_sample_r <= ram_rdata;
      out_done_r   <= done_r;
    end
  end

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) == done_r)
    else $error("done flag and phase disagree");

  a_no_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en |-> phase_r != PH_DONE)
    else $error("sample write after the field was complete");

endmodule

// ===== hdl/diamond_square_noise_field.sv =====
// top level of the diamond-square noise field generator
//
// channel  | ports                                             | dir | role
// ---------+---------------------------------------------------+-----+-------------------------
// in       | in_valid/in_ready, in_req_type, in_random_fraction | in  | supply, read or restart
//          | in_read_x, in_read_y                              |     |
// out      | out_valid/out_ready, out_sample_value,            | out | one beat per read request
//          | out_field_done                                    |     |
// cfg      | cfg_valid/cfg_ready, cfg_feature_log2             | in  | seed spacing, always ready
//
// steps: a diamond or edge supply runs the accept, four neighbor reads and the write through
//   the single sample ram port, the last edge supply of a pass then the scale update on the
//   shared multiplier; a seed writes its sample, a read reads and then loads the output
// reset: rst_n synchronous; the sample ram is not cleared, the generator restarts at seeding
// stalls: a read waits in its last step while the output register holds an untaken beat;
//   that beat is separate from the input, so the next request is taken once the step is done
// a new spacing takes effect at the next restart
module diamond_square_noise_field
  import dsn_pkg::*;
#(
  parameter int FIELD_LOG2 = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [23:0] in_random_fraction,
  input  logic [6:0]  in_read_x,
  input  logic [6:0]  in_read_y,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_sample_value,
  output logic        out_field_done,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_feature_log2
);

  localparam int AW    = 2 * FIELD_LOG2;
  localparam int DEPTH = 1 << AW;

  ctrl_word_t  ctrl;
  dsn_status_t status;
  logic        in_accept;
  logic        cfg_we;

  logic          ram_re, ram_we;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [23:0]   ram_wdata, ram_rdata;

  // the register is a plain flop, so writes are never held off
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_accept = in_valid & in_ready;

  // step counter and control store; requests are taken only at the idle step
  dsn_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .status      (status),
    .in_ready    (in_ready),
    .ctrl        (ctrl)
  );

  // cursor, scales, neighbor addressing, blend arithmetic and the output register
  dsn_dp #(
    .FIELD_LOG2 (FIELD_LOG2)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .in_accept          (in_accept),
    .in_random_fraction (in_random_fraction),
    .in_read_x          (in_read_x),
    .in_read_y          (in_read_y),
    .cfg_we             (cfg_we),
    .cfg_feature_log2   (cfg_feature_log2),
    .status             (status),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_value   (out_sample_value),
    .out_field_done     (out_field_done)
  );

  // sample store, row-major, {y, x} addressing, q4.20 entries
  dsn_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
